FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte controller package
// Shared types, command codes and bus phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 4;

  localparam logic [CntW-1:0] BitsPerByte = 4'd8;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START_WR = 3'd1,
    OP_START_RD = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ_ACK = 3'd4,
    OP_READ_END = 3'd5,
    OP_STOP     = 3'd6,
    OP_RSVD     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_NACK = 2'd1,
    ST_DATA_NACK = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef enum logic [16:0] {
    PH_IDLE  = 17'h00001,
    PH_ST_A  = 17'h00002,
    PH_ST_B  = 17'h00004,
    PH_ST_C  = 17'h00008,
    PH_ST_D  = 17'h00010,
    PH_TX_LO = 17'h00020,
    PH_TX_HI = 17'h00040,
    PH_TA_LO = 17'h00080,
    PH_TA_HI = 17'h00100,
    PH_RX_LO = 17'h00200,
    PH_RX_HI = 17'h00400,
    PH_RA_LO = 17'h00800,
    PH_RA_HI = 17'h01000,
    PH_END   = 17'h02000,
    PH_SP_A  = 17'h04000,
    PH_SP_B  = 17'h08000,
    PH_SP_C  = 17'h10000
  } phase_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [ByteW-1:0] data_byte;
    logic             sda_in;
  } in_word_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             ready_res;
    logic             cmd_done;
    logic [ByteW-1:0] rx_byte;
    logic [1:0]       status;
  } res_word_t;

endpackage

`default_nettype wire

FILE: design/i2cm_in_reg.sv
// ----------------------------------------------------------------------------
// I2C master input register
// Holds one accepted tick word until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_in_reg
  import i2cm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          stall_o,
  input  wire in_word_t word_i,
  input  wire logic     take_i,
  output logic          valid_o,
  output in_word_t      word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

FILE: design/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master protocol engine
// Advances the bus state machine by one phase for every tick word consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire in_word_t         word_i,
  input  wire logic [AddrW-1:0] target_addr_i,
  output res_word_t             res_o
);

  phase_e           phase_q, phase_d;
  op_e              pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  status_e          status_q, status_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             done;
  op_e              op;

  assign op = op_e'(word_i.op);

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    status_d = status_q;
    rx_d     = rx_q;
    done     = 1'b0;

    // A command is taken only when idle; the same tick runs its first phase.
    if (phase_q == PH_IDLE && op != OP_TICK && op != OP_RSVD) begin
      pend_d   = op;
      status_d = ST_OK;
      cnt_d    = '0;
      case (op)
        OP_START_WR, OP_START_RD: begin
          shift_d = {target_addr_i, op == OP_START_RD};
          phase_d = PH_ST_A;
        end
        OP_WRITE: begin
          shift_d = word_i.data_byte;
          phase_d = PH_TX_LO;
        end
        OP_READ_ACK, OP_READ_END: begin
          shift_d = '0;
          phase_d = PH_RX_LO;
        end
        default: begin
          phase_d = PH_SP_A;
        end
      endcase
    end

    case (phase_d)
      PH_ST_A: begin
        sda_d   = 1'b1;
        phase_d = PH_ST_B;
      end
      PH_ST_B: begin
        scl_d   = 1'b1;
        phase_d = PH_ST_C;
      end
      PH_ST_C: begin
        sda_d   = 1'b0;
        phase_d = PH_ST_D;
      end
      PH_ST_D: begin
        scl_d   = 1'b0;
        cnt_d   = '0;
        phase_d = PH_TX_LO;
      end
      PH_TX_LO: begin
        scl_d   = 1'b0;
        sda_d   = shift_d[ByteW-1];
        phase_d = PH_TX_HI;
      end
      PH_TX_HI: begin
        scl_d   = 1'b1;
        shift_d = {shift_d[ByteW-2:0], 1'b0};
        cnt_d   = cnt_d + 1'b1;
        phase_d = (cnt_d >= BitsPerByte) ? PH_TA_LO : PH_TX_LO;
      end
      PH_TA_LO: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        phase_d = PH_TA_HI;
      end
      PH_TA_HI: begin
        scl_d = 1'b1;
        if (word_i.sda_in) begin
          status_d = (pend_d == OP_WRITE) ? ST_DATA_NACK : ST_ADDR_NACK;
          phase_d  = PH_SP_A;
        end else begin
          phase_d = PH_END;
        end
      end
      PH_RX_LO: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        phase_d = PH_RX_HI;
      end
      PH_RX_HI: begin
        scl_d   = 1'b1;
        shift_d = {shift_d[ByteW-2:0], word_i.sda_in};
        cnt_d   = cnt_d + 1'b1;
        phase_d = (cnt_d >= BitsPerByte) ? PH_RA_LO : PH_RX_LO;
      end
      PH_RA_LO: begin
        scl_d   = 1'b0;
        sda_d   = (pend_d == OP_READ_END);
        rx_d    = shift_d;
        phase_d = PH_RA_HI;
      end
      PH_RA_HI: begin
        scl_d   = 1'b1;
        phase_d = (pend_d == OP_READ_END) ? PH_SP_A : PH_END;
      end
      PH_END: begin
        scl_d   = 1'b0;
        done    = 1'b1;
        phase_d = PH_IDLE;
      end
      PH_SP_A: begin
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        phase_d = PH_SP_B;
      end
      PH_SP_B: begin
        scl_d   = 1'b1;
        phase_d = PH_SP_C;
      end
      PH_SP_C: begin
        sda_d   = 1'b1;
        done    = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pend_q   <= OP_TICK;
      cnt_q    <= '0;
      shift_q  <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      status_q <= ST_OK;
      rx_q     <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      status_q <= status_d;
      rx_q     <= rx_d;
    end
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = sda_d;
  assign res_o.ready_res = (phase_d == PH_IDLE);
  assign res_o.cmd_done  = done;
  assign res_o.rx_byte   = rx_d;
  assign res_o.status    = status_d;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("bus phase register is not one-hot");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BitsPerByte)
    else $error("bit counter ran past one byte");

  a_done_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PH_IDLE)
    else $error("command finished but engine did not return to idle");

  a_stop_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_SP_C |=> scl_q && sda_q)
    else $error("bus not released after stop condition");

endmodule

`default_nettype wire

FILE: design/i2cm_out_reg.sv
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire res_word_t word_i,
  output logic           room_o,
  output logic           valid_o,
  input  wire logic      stall_i,
  output res_word_t      word_o
);

  logic      valid_q, valid_d;
  res_word_t word_q;

  // A new word may enter when the register is empty or is emptied this cycle.
  assign room_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

FILE: design/i2c_master_byte_controller_core.sv
// ----------------------------------------------------------------------------
// I2C master byte controller core
// 7-bit-address I2C master that moves the bus one phase per tick word.
//
// Each input word is one bus timing tick: a command code, a byte to send and
// the sampled SDA level. When the controller is idle a tick may start a start,
// write, read or stop command; ticks that arrive while busy only advance the
// running command. Every input word yields exactly one result word with the
// SCL and SDA levels to drive, idle and done flags, the last received byte
// and the status of the latest command.
// From input acceptance to result valid, the word waits in the input register
// until the engine steps, which loads its result into the result register.
// Throughput is one word per cycle when the receiver does not stall.
// When the receiver stalls, the result is held and the input register fills;
// input stall then follows output stall in the same cycle.
// Reset returns the engine to idle with both bus lines released, status ok,
// received byte zero and the target address zero. The target address must be
// written through cfg_we_i while the controller is idle; no logic enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_controller_core
  import i2cm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [2:0]       op_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             sda_in_i,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  scl_level_o,
  output logic                  sda_level_o,
  output logic                  ready_res_o,
  output logic                  cmd_done_o,
  output logic [ByteW-1:0]      rx_byte_o,
  output logic [1:0]            status_o
);

  logic             [AddrW-1:0] target_addr_q;
  in_word_t         in_word, held_word;
  logic             held_valid;
  logic             out_room;
  logic             step;
  res_word_t        res_word, out_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_addr_q <= '0;
    end else if (cfg_we_i) begin
      target_addr_q <= cfg_wdata_i;
    end
  end

  assign in_word.op        = op_i;
  assign in_word.data_byte = data_byte_i;
  assign in_word.sda_in    = sda_in_i;

  assign step = held_valid && out_room;

  i2cm_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .word_i  (in_word),
    .take_i  (step),
    .valid_o (held_valid),
    .word_o  (held_word)
  );

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .word_i        (held_word),
    .target_addr_i (target_addr_q),
    .res_o         (res_word)
  );

  i2cm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .word_i  (res_word),
    .room_o  (out_room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word)
  );

  assign scl_level_o = out_word.scl_level;
  assign sda_level_o = out_word.sda_level;
  assign ready_res_o = out_word.ready_res;
  assign cmd_done_o  = out_word.cmd_done;
  assign rx_byte_o   = out_word.rx_byte;
  assign status_o    = out_word.status;

endmodule

`default_nettype wire
